// ----- hdl/ddsqrt_pkg.sv -----
// Package for the decimal digit-by-digit square root pipeline.
// Holds sizes, item types and stage payload types; no dependencies.
package ddsqrt_pkg;

  localparam int IN_W             = 27;
  localparam int INT_DIGITS       = 8;
  localparam int ROOT_FRAC_DIGITS = 8;
  localparam int FRAC_IN_DIGITS   = 8;

  localparam int RI_W = 14;
  localparam int RF_W = 27;

  localparam int INT_LEN    = INT_DIGITS + (INT_DIGITS % 2);
  localparam int INT_PAIRS  = INT_LEN / 2;
  localparam int NUM_PAIRS  = INT_PAIRS + ROOT_FRAC_DIGITS;
  localparam int NUM_DIGITS = 2 * NUM_PAIRS;

  // decimal digits needed for an IN_W-bit binary value
  localparam int BCD_DIGITS = ((IN_W * 1233) >> 12) + 1;
  localparam int DD_STEPS   = 7;
  localparam int DD_STAGES  = (IN_W + DD_STEPS - 1) / DD_STEPS;
  localparam int CNT_W      = $clog2(IN_W + 1);

  // root < 10^NUM_PAIRS; remainder < 100 * (2 * root + 1)
  localparam int ROOT_W = (NUM_PAIRS * 3322) / 1000 + 1;
  localparam int REM_W  = ROOT_W + 8;
  localparam int PCNT_W = $clog2(NUM_PAIRS + 1);

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam logic [63:0] INT_MAX  = pow10(INT_DIGITS) - 64'd1;
  localparam logic [63:0] FRAC_MAX = pow10(FRAC_IN_DIGITS) - 64'd1;

  typedef struct packed {
    logic [IN_W-1:0] integer_part;
    logic [IN_W-1:0] fraction_part;
  } in_item_t;

  typedef struct packed {
    logic [RI_W-1:0] root_integer;
    logic [RF_W-1:0] root_fraction;
    logic            exact_flag;
  } out_item_t;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic [IN_W-1:0]  ibin;
    logic [IN_W-1:0]  fbin;
    bcd_t             ibcd;
    bcd_t             fbcd;
    logic [CNT_W-1:0] count;
  } conv_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digs;
    logic [ROOT_W-1:0]          root;
    logic [REM_W-1:0]           rem;
    logic [RI_W-1:0]            ri;
    logic [RF_W-1:0]            rf;
    logic                       dropped;
    logic [PCNT_W-1:0]          count;
  } root_t;

endpackage

// ----- hdl/ddsqrt_bcd_stage.sv -----
// One stage of the binary to BCD converter (shift-and-add-3).
// Converts integer and fraction in parallel; uses ddsqrt_pkg.
module ddsqrt_bcd_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  ddsqrt_pkg::conv_t  up_item,
  input  logic               dn_adv,
  output logic               valid_r,
  output ddsqrt_pkg::conv_t  item_r,
  output logic               adv
);

  function automatic ddsqrt_pkg::bcd_t dabble(input ddsqrt_pkg::bcd_t b, input logic bit_in);
    ddsqrt_pkg::bcd_t                     a;
    logic [4*ddsqrt_pkg::BCD_DIGITS-1:0] f;
    for (int i = 0; i < ddsqrt_pkg::BCD_DIGITS; i++) begin
      a[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
    end
    f = a;
    f = {f[4*ddsqrt_pkg::BCD_DIGITS-2:0], bit_in};
    return f;
  endfunction

  ddsqrt_pkg::conv_t item_nxt;

  assign adv = !valid_r || dn_adv;

  always_comb begin
    item_nxt = up_item;
    for (int s = 0; s < ddsqrt_pkg::DD_STEPS; s++) begin
      if (item_nxt.count < ddsqrt_pkg::CNT_W'(ddsqrt_pkg::IN_W)) begin
        item_nxt.ibcd  = dabble(item_nxt.ibcd, item_nxt.ibin[ddsqrt_pkg::IN_W-1]);
        item_nxt.fbcd  = dabble(item_nxt.fbcd, item_nxt.fbin[ddsqrt_pkg::IN_W-1]);
        item_nxt.ibin  = {item_nxt.ibin[ddsqrt_pkg::IN_W-2:0], 1'b0};
        item_nxt.fbin  = {item_nxt.fbin[ddsqrt_pkg::IN_W-2:0], 1'b0};
        item_nxt.count = item_nxt.count + ddsqrt_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- hdl/ddsqrt_digit_stage.sv -----
// One root digit step: bring down a digit pair, pick the largest trial digit.
// Uses ddsqrt_pkg.
module ddsqrt_digit_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  ddsqrt_pkg::root_t  up_item,
  input  logic               dn_adv,
  output logic               valid_r,
  output ddsqrt_pkg::root_t  item_r,
  output logic               adv
);

  localparam int RW = ddsqrt_pkg::REM_W;
  localparam int ND = ddsqrt_pkg::NUM_DIGITS;

  logic [6:0]        pair;
  logic [RW-1:0]     rem_a;
  logic [RW-1:0]     t2;
  logic [RW-1:0]     trial [0:9];
  logic [3:0]        dsel;
  ddsqrt_pkg::root_t item_nxt;

  assign adv = !valid_r || dn_adv;

  always_comb begin
    pair  = ({3'b0, up_item.digs[ND-1]} << 3) + ({3'b0, up_item.digs[ND-1]} << 1)
          + {3'b0, up_item.digs[ND-2]};
    rem_a = (up_item.rem << 6) + (up_item.rem << 5) + (up_item.rem << 2) + RW'(pair);
    t2    = (RW'(up_item.root) << 4) + (RW'(up_item.root) << 2);
    trial[0] = '0;
    for (int k = 1; k <= 9; k++) begin
      trial[k] = t2 * RW'(k) + RW'(k * k);
    end
    // trial values grow with the digit, so the last passing one is the largest
    dsel = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (trial[k] <= rem_a) begin
        dsel = 4'(k);
      end
    end

    item_nxt      = up_item;
    item_nxt.digs = {up_item.digs[ND-3:0], 8'h00};
    item_nxt.rem  = rem_a - trial[dsel];
    item_nxt.root = (up_item.root << 3) + (up_item.root << 1)
                  + ddsqrt_pkg::ROOT_W'(dsel);
    if (up_item.count < ddsqrt_pkg::PCNT_W'(ddsqrt_pkg::INT_PAIRS)) begin
      item_nxt.ri = (up_item.ri << 3) + (up_item.ri << 1) + ddsqrt_pkg::RI_W'(dsel);
    end else begin
      item_nxt.rf = (up_item.rf << 3) + (up_item.rf << 1) + ddsqrt_pkg::RF_W'(dsel);
    end
    item_nxt.count = up_item.count + ddsqrt_pkg::PCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- hdl/decimal_digit_square_root.sv -----
// Top level of the decimal digit-by-digit square root pipeline.
// Instantiates ddsqrt_bcd_stage and ddsqrt_digit_stage; uses ddsqrt_pkg.
//
// Takes I (integer part) and F (8 fraction digits) and returns
// floor(sqrt((I*10^8+F)*10^8)) split into a 4-digit integer part and 8 fraction
// digits, with exact_flag set when the remainder is zero. Inputs above
// 99999999 saturate. The pipeline accepts one item per cycle while in_stall is
// low and is built from an input register, 4 binary-to-BCD stages of up to 7
// shift steps each (27 steps in all), 12 root digit stages (one decimal digit
// each) and an output register. Every stage holds its item under stall and
// empty stages fill in, so in_stall rises only when the whole pipe is full and
// out_stall is high.
module decimal_digit_square_root (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ddsqrt_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ddsqrt_pkg::out_item_t out_item
);

  localparam int NS = ddsqrt_pkg::DD_STAGES;
  localparam int NP = ddsqrt_pkg::NUM_PAIRS;
  localparam int ND = ddsqrt_pkg::NUM_DIGITS;

  logic               in_valid_r;
  ddsqrt_pkg::conv_t  in_conv_r;
  ddsqrt_pkg::conv_t  in_conv_nxt;
  logic               in_adv;

  logic               bv    [0:NS-1];
  ddsqrt_pkg::conv_t  bitem [0:NS-1];
  logic               badv  [0:NS-1];

  logic               dv    [0:NP-1];
  ddsqrt_pkg::root_t  ditem [0:NP-1];
  logic               dadv  [0:NP-1];

  ddsqrt_pkg::root_t  entry;
  ddsqrt_pkg::out_item_t out_item_nxt;
  logic               out_valid_r;
  ddsqrt_pkg::out_item_t out_item_r;
  logic               out_adv;

  // input register with saturation
  assign in_adv   = !in_valid_r || badv[0];
  assign in_stall = !in_adv;

  always_comb begin
    in_conv_nxt       = '0;
    in_conv_nxt.ibin  = in_item.integer_part;
    in_conv_nxt.fbin  = in_item.fraction_part;
    if ({37'b0, in_item.integer_part} > ddsqrt_pkg::INT_MAX) begin
      in_conv_nxt.ibin = ddsqrt_pkg::IN_W'(ddsqrt_pkg::INT_MAX);
    end
    if ({37'b0, in_item.fraction_part} > ddsqrt_pkg::FRAC_MAX) begin
      in_conv_nxt.fbin = ddsqrt_pkg::IN_W'(ddsqrt_pkg::FRAC_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      in_conv_r <= in_conv_nxt;
    end
  end

  // binary to BCD
  genvar gs;
  generate
    for (gs = 0; gs < NS; gs++) begin : g_bcd
      if (gs == 0) begin : g_first
        ddsqrt_bcd_stage u_stage (
          .clk      (clk),
          .rst_n    (rst_n),
          .up_valid (in_valid_r),
          .up_item  (in_conv_r),
          .dn_adv   ((gs == NS - 1) ? dadv[0] : badv[(gs + 1) % NS]),
          .valid_r  (bv[gs]),
          .item_r   (bitem[gs]),
          .adv      (badv[gs])
        );
      end else begin : g_rest
        ddsqrt_bcd_stage u_stage (
          .clk      (clk),
          .rst_n    (rst_n),
          .up_valid (bv[gs - 1]),
          .up_item  (bitem[gs - 1]),
          .dn_adv   ((gs == NS - 1) ? dadv[0] : badv[(gs + 1) % NS]),
          .valid_r  (bv[gs]),
          .item_r   (bitem[gs]),
          .adv      (badv[gs])
        );
      end
    end
  endgenerate

  // digit list: integer digits (padded to even), then fraction digit pairs
  always_comb begin
    entry = '0;
    for (int k = 0; k < ddsqrt_pkg::INT_LEN; k++) begin
      if (k < ddsqrt_pkg::BCD_DIGITS) begin
        entry.digs[ND - ddsqrt_pkg::INT_LEN + k] = bitem[NS-1].ibcd[k];
      end
    end
    for (int k = 0; k < 2 * ddsqrt_pkg::ROOT_FRAC_DIGITS; k++) begin
      if (k < ddsqrt_pkg::FRAC_IN_DIGITS) begin
        entry.digs[ND - ddsqrt_pkg::INT_LEN - 1 - k] =
          bitem[NS-1].fbcd[ddsqrt_pkg::FRAC_IN_DIGITS - 1 - k];
      end
    end
    for (int k = 2 * ddsqrt_pkg::ROOT_FRAC_DIGITS; k < ddsqrt_pkg::FRAC_IN_DIGITS; k++) begin
      if (bitem[NS-1].fbcd[ddsqrt_pkg::FRAC_IN_DIGITS - 1 - k] != 4'd0) begin
        entry.dropped = 1'b1;
      end
    end
  end

  // root digit pipeline
  genvar gp;
  generate
    for (gp = 0; gp < NP; gp++) begin : g_dig
      if (gp == 0) begin : g_first
        ddsqrt_digit_stage u_stage (
          .clk      (clk),
          .rst_n    (rst_n),
          .up_valid (bv[NS-1]),
          .up_item  (entry),
          .dn_adv   ((gp == NP - 1) ? out_adv : dadv[(gp + 1) % NP]),
          .valid_r  (dv[gp]),
          .item_r   (ditem[gp]),
          .adv      (dadv[gp])
        );
      end else begin : g_rest
        ddsqrt_digit_stage u_stage (
          .clk      (clk),
          .rst_n    (rst_n),
          .up_valid (dv[gp - 1]),
          .up_item  (ditem[gp - 1]),
          .dn_adv   ((gp == NP - 1) ? out_adv : dadv[(gp + 1) % NP]),
          .valid_r  (dv[gp]),
          .item_r   (ditem[gp]),
          .adv      (dadv[gp])
        );
      end
    end
  endgenerate

  // output register
  assign out_adv = !out_valid_r || !out_stall;

  always_comb begin
    out_item_nxt.root_integer  = ditem[NP-1].ri;
    out_item_nxt.root_fraction = ditem[NP-1].rf;
    out_item_nxt.exact_flag    = (ditem[NP-1].rem == '0) && !ditem[NP-1].dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= dv[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- sim/decimal_digit_square_root_test.sv -----
// Self-checking testbench for decimal_digit_square_root.
// Drives random and directed radicands, predicts each root digit by digit and
// compares in order; depends on ddsqrt_pkg and the RTL top level only.
`timescale 1ns / 100ps

module decimal_digit_square_root_test;

  localparam longint unsigned DEC8      = 64'd100000000;
  localparam int              N_RANDOM  = 1600;
  localparam int              CYC_LIMIT = 400000;
  localparam int              HOLD_CYC  = 60;

  class root_scoreboard;
    ddsqrt_pkg::out_item_t expected_q[$];
    int                    errors;

    function new();
      errors = 0;
    endfunction

    function ddsqrt_pkg::out_item_t predict_root(ddsqrt_pkg::in_item_t it);
      logic [63:0]  ival;
      logic [63:0]  fval;
      logic [3:0]   digs[ddsqrt_pkg::NUM_DIGITS];
      logic [127:0] rem;
      logic [127:0] root;
      logic [127:0] t2;
      logic [127:0] trial;
      logic [63:0]  ri;
      logic [63:0]  rf;
      int           d;
      int           k;
      ddsqrt_pkg::out_item_t res;
      ival = 64'(it.integer_part);
      fval = 64'(it.fraction_part);
      if (ival > ddsqrt_pkg::INT_MAX) ival = ddsqrt_pkg::INT_MAX;
      if (fval > ddsqrt_pkg::FRAC_MAX) fval = ddsqrt_pkg::FRAC_MAX;
      for (k = ddsqrt_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
        digs[k] = 4'd0;
      end
      for (k = ddsqrt_pkg::INT_LEN - 1; k >= 0; k--) begin
        digs[k] = 4'(ival % 10);
        ival    = ival / 10;
      end
      for (k = ddsqrt_pkg::FRAC_IN_DIGITS - 1; k >= 0; k--) begin
        digs[ddsqrt_pkg::INT_LEN + k] = 4'(fval % 10);
        fval                          = fval / 10;
      end
      rem  = '0;
      root = '0;
      ri   = '0;
      rf   = '0;
      for (k = 0; k < ddsqrt_pkg::NUM_PAIRS; k++) begin
        rem   = rem * 100 + digs[2*k] * 10 + digs[2*k+1];
        t2    = root * 20;
        d     = 9;
        trial = (t2 + d) * d;
        while (d > 0 && trial > rem) begin
          d--;
          trial = (t2 + d) * d;
        end
        rem  = rem - trial;
        root = root * 10 + d;
        if (k < ddsqrt_pkg::INT_PAIRS) ri = ri * 10 + d;
        else rf = rf * 10 + d;
      end
      res.root_integer  = ri[ddsqrt_pkg::RI_W-1:0];
      res.root_fraction = rf[ddsqrt_pkg::RF_W-1:0];
      res.exact_flag    = (rem == 0);
      return res;
    endfunction

    function void note_input(ddsqrt_pkg::in_item_t it);
      expected_q.push_back(predict_root(it));
    endfunction

    function void check_result(ddsqrt_pkg::out_item_t got);
      ddsqrt_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: int=%0d frac=%0d exact=%0d",
                   got.root_integer, got.root_fraction, got.exact_flag);
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.root_integer !== exp_item.root_integer ||
          got.root_fraction !== exp_item.root_fraction ||
          got.exact_flag !== exp_item.exact_flag) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected int=%0d frac=%0d exact=%0d, got int=%0d frac=%0d exact=%0d",
                   exp_item.root_integer, exp_item.root_fraction, exp_item.exact_flag,
                   got.root_integer, got.root_fraction, got.exact_flag);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  ddsqrt_pkg::in_item_t  in_item;
  logic                  out_valid;
  logic                  out_stall;
  ddsqrt_pkg::out_item_t out_item;

  root_scoreboard sb;
  int             inputs_accepted;
  int             cycle_count;
  bit             quiet;
  bit             holding;
  bit             hold_done;

  decimal_digit_square_root i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ddsqrt_pkg::in_item_t mk_item(longint unsigned ip, longint unsigned fp);
    ddsqrt_pkg::in_item_t it;
    it.integer_part  = ip[ddsqrt_pkg::IN_W-1:0];
    it.fraction_part = fp[ddsqrt_pkg::IN_W-1:0];
    return it;
  endfunction

  function automatic ddsqrt_pkg::in_item_t random_radicand();
    longint unsigned      r;
    longint unsigned      sq;
    int                   kind;
    ddsqrt_pkg::in_item_t it;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        it = mk_item($urandom_range(0, 99999999), $urandom_range(0, 99999999));
      end
      4: begin
        it.integer_part  = ddsqrt_pkg::IN_W'($urandom);
        it.fraction_part = ddsqrt_pkg::IN_W'($urandom);
      end
      5, 6: begin
        it = mk_item($urandom_range(0, 99), $urandom_range(0, 99999999));
      end
      7, 8: begin
        // exact root with up to four fraction digits
        r  = $urandom_range(0, 99999999);
        sq = r * r;
        it = mk_item(sq / DEC8, sq % DEC8);
      end
      default: begin
        it = mk_item(99999999 - $urandom_range(0, 3) + $urandom_range(0, 3),
                     99999999 - $urandom_range(0, 3) + $urandom_range(0, 3));
      end
    endcase
    return it;
  endfunction

  task automatic send_item(ddsqrt_pkg::in_item_t it);
    if (!quiet && !holding && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_item);
        inputs_accepted++;
      end
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // receiver side: random stall bursts plus one long hold-off
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && inputs_accepted >= 400) begin
        hold_done = 1'b1;
        holding   = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        out_stall = 1'b0;
        holding   = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYC_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    ddsqrt_pkg::in_item_t directed[$];
    sb              = new();
    inputs_accepted = 0;
    quiet           = 1'b0;
    holding         = 1'b0;
    hold_done       = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_item         = '0;
    directed = '{mk_item(0, 0), mk_item(0, 1), mk_item(1, 0), mk_item(2, 0),
                 mk_item(4, 0), mk_item(144, 0), mk_item(1, 44000000),
                 mk_item(2, 25000000), mk_item(0, 25000000), mk_item(0, 99999999),
                 mk_item(99999999, 0), mk_item(99999999, 99999999),
                 mk_item(100000000, 0), mk_item(0, 100000000),
                 mk_item(134217727, 134217727), mk_item(99980001, 0),
                 mk_item(10000000, 0), mk_item(12345678, 87654321),
                 mk_item(9999, 99999999), mk_item(3, 0)};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_item(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 700 && i < 800) || (i >= N_RANDOM - 200);
      send_item(random_radicand());
    end
    in_valid = 1'b0;
    quiet    = 1'b1;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ddsqrt_pkg.sv
hdl/ddsqrt_bcd_stage.sv
hdl/ddsqrt_digit_stage.sv
hdl/decimal_digit_square_root.sv
sim/decimal_digit_square_root_test.sv
